// ----- design/tcw_pkg.sv -----
// Shared types, codes and default sizes of the text console cell writer.
package tcw_pkg;

  localparam int unsigned DefaultCols = 80;
  localparam int unsigned DefaultRows = 25;

  localparam logic [7:0] CHAR_NEWLINE     = 8'd10;
  localparam logic [7:0] CHAR_SPACE       = 8'd32;
  localparam logic [7:0] DEFAULT_ATTR_RST = 8'd15;

  typedef enum logic [1:0] {
    CMD_PUT       = 2'd0,
    CMD_BACKSPACE = 2'd1,
    CMD_CLEAR     = 2'd2,
    CMD_READ      = 2'd3
  } tcw_cmd_e;

  typedef struct packed {
    tcw_cmd_e   command;
    logic [7:0] character;
    logic [7:0] attribute;
    logic       use_position;
    logic [7:0] column;
    logic [6:0] row;
  } tcw_cmd_t;

  typedef struct packed {
    logic [7:0] cursor_column;
    logic [6:0] cursor_row;
    logic [7:0] read_character;
    logic [7:0] read_attribute;
    logic       scrolled;
    logic       position_error;
  } tcw_res_t;

endpackage

// ----- design/tcw_stream_if.sv -----
// Valid/ready stream channel carrying one payload beat.
interface tcw_stream_if #(
  parameter type T = logic
) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ----- design/tcw_ram.sv -----
// Generic single-write, single-read synchronous RAM with registered read data.
module tcw_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 2000,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

// ----- design/text_console_cell_writer.sv -----
// Top level of the text console cell writer: cell store, cursor and command sequencer.
//
//   Channel            Dir  Handshake                  Payload
//   cmd_i              in   valid/ready                tcw_cmd_t (command, character, ...)
//   res_o              out  valid/ready                tcw_res_t (cursor, read cell, flags)
//   default_attribute  in   default_attribute_we_i     default_attribute_i, 8 bits
//
// An ordinary put, backspace or read uses ST_EXEC to compute the cell address (row times
// COLS plus column) and access the cell store, then ST_DONE to present the result beat.
// The store has one write and one read port, so a scroll moves each cell below the top row
// up one row, then zeroes the last row; a clear fills every cell with a default-attribute
// space. After reset the store is swept to zero, one cell a cycle, over all ROWS*COLS cells
// (2000 at 80 by 25); no command beat is taken until that pass is done, but the attribute
// register can be written at any time. A held result beat does not stop the next command
// beat from being accepted; that command then waits with its own result until res_o drains.
module text_console_cell_writer #(
  parameter int unsigned COLS = tcw_pkg::DefaultCols,
  parameter int unsigned ROWS = tcw_pkg::DefaultRows
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        default_attribute_we_i,
  input  logic [7:0]  default_attribute_i,
  tcw_stream_if.sink   cmd_i,
  tcw_stream_if.source res_o
);

  localparam int unsigned CELLS = ROWS * COLS;
  localparam int unsigned AW    = (CELLS > 1) ? $clog2(CELLS) : 1;
  localparam int unsigned CW    = (COLS > 1) ? $clog2(COLS) : 1;
  localparam int unsigned RW    = (ROWS > 1) ? $clog2(ROWS) : 1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_SCROLL,
    ST_FILL,
    ST_DONE
  } state_e;

  state_e           state_q;
  logic             init_q;
  logic [AW-1:0]    cnt_q;
  logic [15:0]      fill_q;
  logic             pend_q;
  logic [AW-1:0]    pend_addr_q;
  logic [CW-1:0]    cur_col_q;
  logic [RW-1:0]    cur_row_q;
  logic [7:0]       def_attr_q;
  tcw_pkg::tcw_cmd_t cmd_q;
  logic             res_scrolled_q;
  logic             res_perr_q;
  logic             res_rdok_q;
  logic             out_valid_q;
  tcw_pkg::tcw_res_t out_q;

  // Cell store port signals.
  logic             ram_we;
  logic [AW-1:0]    ram_waddr;
  logic [15:0]      ram_wdata;
  logic             ram_re;
  logic [AW-1:0]    ram_raddr;
  logic [15:0]      ram_rdata;

  // Command decode.
  logic             in_accept;
  logic             out_free;
  logic             on_screen;
  logic [CW-1:0]    col_idx;
  logic [RW-1:0]    row_idx;
  logic [CW-1:0]    p_col;
  logic [RW-1:0]    p_row;
  logic [RW:0]      p_row_inc;
  logic             is_newline;
  logic             wrap;
  logic [CW-1:0]    n_col;
  logic [RW:0]      n_row_w;
  logic             do_scroll;
  logic [RW-1:0]    n_row;
  logic [CW-1:0]    bs_col;
  logic [RW-1:0]    bs_row;
  logic [CW-1:0]    a_col;
  logic [RW-1:0]    a_row;
  logic [AW-1:0]    cell_addr;
  logic [7:0]       attr_eff;
  logic             put_ok;
  tcw_pkg::tcw_res_t res_d;

  assign out_free    = !out_valid_q || res_o.ready;
  assign cmd_i.ready = (state_q == ST_IDLE) || ((state_q == ST_DONE) && out_free);
  assign in_accept   = cmd_i.valid && cmd_i.ready;
  assign res_o.valid = out_valid_q;
  assign res_o.data  = out_q;

  // The given position is checked at full field width before it is narrowed.
  assign on_screen = ({1'b0, cmd_q.column} < 9'(COLS)) && ({1'b0, cmd_q.row} < 8'(ROWS));
  assign col_idx   = cmd_q.column[CW-1:0];
  assign row_idx   = cmd_q.row[RW-1:0];

  assign p_col      = cmd_q.use_position ? col_idx : cur_col_q;
  assign p_row      = cmd_q.use_position ? row_idx : cur_row_q;
  assign p_row_inc  = {1'b0, p_row} + 1'b1;
  assign is_newline = (cmd_q.character == tcw_pkg::CHAR_NEWLINE);
  assign wrap       = is_newline || (p_col == CW'(COLS - 1));
  assign n_col      = wrap ? '0 : p_col + 1'b1;
  assign n_row_w    = wrap ? p_row_inc : {1'b0, p_row};
  // Running off the bottom scrolls once and leaves the cursor on the last row.
  assign do_scroll  = (n_row_w == (RW + 1)'(ROWS));
  assign n_row      = do_scroll ? RW'(ROWS - 1) : n_row_w[RW-1:0];
  assign put_ok     = !cmd_q.use_position || on_screen;
  assign attr_eff   = (cmd_q.attribute == 8'd0) ? def_attr_q : cmd_q.attribute;

  // Backspace steps back one cell, wrapping to the end of the row above; at home it stays.
  always_comb begin
    if (cur_col_q != '0) begin
      bs_col = cur_col_q - 1'b1;
      bs_row = cur_row_q;
    end else if (cur_row_q != '0) begin
      bs_col = CW'(COLS - 1);
      bs_row = cur_row_q - 1'b1;
    end else begin
      bs_col = '0;
      bs_row = '0;
    end
  end

  always_comb begin
    unique case (cmd_q.command)
      tcw_pkg::CMD_PUT: begin
        a_col = p_col;
        a_row = p_row;
      end
      tcw_pkg::CMD_BACKSPACE: begin
        a_col = bs_col;
        a_row = bs_row;
      end
      default: begin
        a_col = col_idx;
        a_row = row_idx;
      end
    endcase
  end

  assign cell_addr = AW'(AW'(a_row) * AW'(COLS) + AW'(a_col));

  // Store port control. A pending scroll write-back has the write port first.
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = cell_addr;
    ram_wdata = '0;
    ram_re    = 1'b0;
    ram_raddr = cell_addr;
    unique case (state_q)
      ST_EXEC: begin
        unique case (cmd_q.command)
          tcw_pkg::CMD_PUT: begin
            ram_we    = put_ok && !is_newline;
            ram_wdata = {attr_eff, cmd_q.character};
          end
          tcw_pkg::CMD_BACKSPACE: begin
            ram_we    = 1'b1;
            ram_wdata = {def_attr_q, tcw_pkg::CHAR_SPACE};
          end
          tcw_pkg::CMD_READ: begin
            ram_re = on_screen;
          end
          tcw_pkg::CMD_CLEAR: begin
            ram_we = 1'b0;
          end
        endcase
      end
      ST_SCROLL: begin
        ram_re    = 1'b1;
        ram_raddr = cnt_q;
      end
      ST_FILL: begin
        ram_we    = 1'b1;
        ram_waddr = cnt_q;
        ram_wdata = fill_q;
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
    if (pend_q) begin
      ram_we    = 1'b1;
      ram_waddr = pend_addr_q;
      ram_wdata = ram_rdata;
    end
  end

  // The read data stays in the RAM output register while the result waits.
  always_comb begin
    res_d.cursor_column  = 8'(cur_col_q);
    res_d.cursor_row     = 7'(cur_row_q);
    res_d.read_character = res_rdok_q ? ram_rdata[7:0] : 8'd0;
    res_d.read_attribute = res_rdok_q ? ram_rdata[15:8] : 8'd0;
    res_d.scrolled       = res_scrolled_q;
    res_d.position_error = res_perr_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_FILL;
      init_q         <= 1'b1;
      cnt_q          <= '0;
      fill_q         <= '0;
      pend_q         <= 1'b0;
      pend_addr_q    <= '0;
      cur_col_q      <= '0;
      cur_row_q      <= '0;
      def_attr_q     <= tcw_pkg::DEFAULT_ATTR_RST;
      cmd_q          <= '0;
      res_scrolled_q <= 1'b0;
      res_perr_q     <= 1'b0;
      res_rdok_q     <= 1'b0;
      out_valid_q    <= 1'b0;
      out_q          <= '0;
    end else begin
      if (default_attribute_we_i) begin
        def_attr_q <= default_attribute_i;
      end
      // Each scroll read is written back one row higher in the following cycle.
      pend_q      <= (state_q == ST_SCROLL);
      pend_addr_q <= cnt_q - AW'(COLS);
      if (out_valid_q && res_o.ready) begin
        out_valid_q <= 1'b0;
      end
      if (in_accept) begin
        cmd_q <= cmd_i.data;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (in_accept) begin
            state_q <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          res_scrolled_q <= 1'b0;
          res_perr_q     <= 1'b0;
          res_rdok_q     <= 1'b0;
          state_q        <= ST_DONE;
          unique case (cmd_q.command)
            tcw_pkg::CMD_PUT: begin
              if (!put_ok) begin
                res_perr_q <= 1'b1;
              end else begin
                cur_col_q      <= n_col;
                cur_row_q      <= n_row;
                res_scrolled_q <= do_scroll;
                if (do_scroll) begin
                  if (CELLS > COLS) begin
                    state_q <= ST_SCROLL;
                    cnt_q   <= AW'(COLS);
                  end else begin
                    state_q <= ST_FILL;
                    cnt_q   <= AW'(CELLS - COLS);
                    fill_q  <= '0;
                  end
                end
              end
            end
            tcw_pkg::CMD_BACKSPACE: begin
              cur_col_q <= bs_col;
              cur_row_q <= bs_row;
            end
            tcw_pkg::CMD_CLEAR: begin
              cur_col_q <= '0;
              cur_row_q <= '0;
              cnt_q     <= '0;
              fill_q    <= {def_attr_q, tcw_pkg::CHAR_SPACE};
              state_q   <= ST_FILL;
            end
            tcw_pkg::CMD_READ: begin
              res_perr_q <= !on_screen;
              res_rdok_q <= on_screen;
            end
          endcase
        end
        ST_SCROLL: begin
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == AW'(CELLS - 1)) begin
            state_q <= ST_FILL;
            cnt_q   <= AW'(CELLS - COLS);
            fill_q  <= '0;
          end
        end
        ST_FILL: begin
          if (!pend_q) begin
            cnt_q <= cnt_q + 1'b1;
            if (cnt_q == AW'(CELLS - 1)) begin
              if (init_q) begin
                init_q  <= 1'b0;
                state_q <= ST_IDLE;
              end else begin
                state_q <= ST_DONE;
              end
            end
          end
        end
        ST_DONE: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            out_q       <= res_d;
            state_q     <= in_accept ? ST_EXEC : ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  tcw_ram #(
    .WIDTH (16),
    .DEPTH (CELLS)
  ) u_cell_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

endmodule
